@@ rtl/core/sve_pkg.sv @@
// ----------------------------------------------------------------------------
// sve_pkg
// Shared types, constants and tables of the sine voice engine.
// ----------------------------------------------------------------------------
package sve_pkg;

  localparam int VOICES          = 8;
  localparam int SINE_TABLE_BITS = 10;

  localparam int CNT_W   = $clog2(VOICES + 1);
  localparam int PHASE_W = 32;
  localparam int LEVEL_W = 24;
  localparam int MUL_W   = 25;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int TERM_W  = 18;
  localparam int SUM_W   = TERM_W + $clog2(VOICES) + 1;

  // action codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_AMPLITUDE    = 2'd0;
  localparam logic [1:0] CFG_DECAY_SELECT = 2'd1;
  localparam logic [1:0] CFG_ATTACK_RATE  = 2'd2;
  localparam logic [1:0] CFG_DROP_LEVEL   = 2'd3;

  localparam logic [15:0] AMPLITUDE_RST    = 16'd32768;
  localparam logic [3:0]  DECAY_SELECT_RST = 4'd5;
  localparam logic [23:0] ATTACK_RATE_RST  = 24'd16609443;
  localparam logic [23:0] DROP_LEVEL_RST   = 24'd16777;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 24'hFFFFFF;

  // sine polynomial coefficients, Q16
  localparam logic [16:0] SINE_C1 = 17'd102944;
  localparam logic [15:0] SINE_C3 = 16'd42334;
  localparam logic [12:0] SINE_C5 = 13'd5223;

  localparam logic [23:0] DECAY_TABLE [10] = '{
    24'd16603360, 24'd16770227, 24'd16773721, 24'd16775468, 24'd16776342,
    24'd16776779, 24'd16776925, 24'd16776966, 24'd16777022, 24'd16777041
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_DONE
  } state_t;

  // steps of the shared multiplier sequence
  typedef enum logic [3:0] {
    MS_XX,
    MS_X2C5,
    MS_T1,
    MS_T2,
    MS_GD,
    MS_EA,
    MS_ES,
    MS_ATT,
    MS_DEC,
    MS_FIN
  } mstep_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PHASE_W-1:0] step;
    logic [LEVEL_W-1:0] att;
    logic [LEVEL_W-1:0] dec;
    logic [LEVEL_W-1:0] arate;
    logic [LEVEL_W-1:0] drate;
  } voice_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic                     done;
    logic                     keep;
    logic signed [TERM_W-1:0] term;
  } unit_res_t;

  function automatic logic [LEVEL_W-1:0] decay_rate(input logic [3:0] sel);
    logic [3:0] s;
    s = (sel > 4'd9) ? 4'd9 : sel;
    return DECAY_TABLE[s];
  endfunction

endpackage

@@ rtl/core/sve_if.sv @@
// ----------------------------------------------------------------------------
// sve_if
// Valid/ready channels of the sine voice engine.
// ----------------------------------------------------------------------------
interface sve_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] phase_step;

  modport source (output valid, action, phase_step, input ready);
  modport sink   (input valid, action, phase_step, output ready);
endinterface

interface sve_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [3:0]         voices_active;

  modport source (output valid, sample, voices_active, input ready);
  modport sink   (input valid, sample, voices_active, output ready);
endinterface

@@ rtl/core/polyphonic_sine_voice_engine.sv @@
// ----------------------------------------------------------------------------
// polyphonic_sine_voice_engine
// Polyphonic sine voices with exponential attack and decay envelopes.
// ----------------------------------------------------------------------------
// Add and remove items are applied directly to the chain. A tick walks the
// voices through one shared multiplier: a sounding voice takes a start state,
// nine multiplies and a closing step, a voice with zero step finishes right
// after its start state, so the length of a tick is set by that single
// multiplier. The voices sit in a chain of slots, oldest at the head; the head
// is processed and the chain shifts one place per voice. The next item is
// taken once the tick's sample is in the output register.
module polyphonic_sine_voice_engine (
  input  logic        clk,
  input  logic        rst_n,
  sve_in_if.sink      in_ch,
  sve_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import sve_pkg::*;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, len_r, rem_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     out_valid_r;
  logic signed [15:0]       out_sample_r;
  logic [3:0]               out_active_r;
  logic [15:0]              amp_r;
  logic [3:0]               dsel_r;
  logic [23:0]              arate_r, drop_r;

  logic                     in_ready, accept, unit_start, out_load;
  logic                     chain_shift, chain_load;
  logic [CNT_W-1:0]         shift_len, load_pos;
  voice_t                   add_rec, new_rec, upd;
  voice_t                   q [VOICES];
  cell_ctl_t                ctl [VOICES];
  unit_res_t                res;
  logic signed [15:0]       sat;

  assign accept = in_ch.valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.action == ACT_TICK) begin
          state_nxt = (cnt_r == '0) ? ST_DONE : ST_START;
        end
      end
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (res.done) begin
          state_nxt = (rem_r == CNT_W'(1)) ? ST_DONE : ST_START;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    unit_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready   = 1'b1;
      ST_START: unit_start = 1'b1;
      ST_DONE:  out_load   = !out_valid_r || out_ch.ready;
      default:  ;
    endcase
  end

  assign add_rec = '{phase: '0, step: in_ch.phase_step, att: LEVEL_FULL, dec: LEVEL_FULL,
                     arate: arate_r, drate: decay_rate(dsel_r)};

  always_comb begin
    chain_shift = 1'b0;
    chain_load  = 1'b0;
    shift_len   = CNT_W'(VOICES);
    load_pos    = '0;
    new_rec     = add_rec;
    if (accept && in_ch.action == ACT_ADD) begin
      chain_load = 1'b1;
      if (cnt_r == CNT_W'(VOICES)) begin
        chain_shift = 1'b1;
        load_pos    = CNT_W'(VOICES - 1);
      end else begin
        load_pos = cnt_r;
      end
    end else if (accept && in_ch.action == ACT_REMOVE) begin
      chain_shift = 1'b1;
    end else if (state_r == ST_WAIT && res.done) begin
      // head leaves; a kept voice re-enters at the window's tail
      chain_shift = 1'b1;
      shift_len   = len_r;
      chain_load  = res.keep;
      load_pos    = len_r - CNT_W'(1);
      new_rec     = upd;
    end
  end

  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    assign ctl[i].shift = chain_shift && (CNT_W'(i + 1) < shift_len);
    assign ctl[i].load  = chain_load && (CNT_W'(i) == load_pos);
    sve_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[i]),
      .right   ((i == VOICES - 1) ? new_rec : q[(i + 1) % VOICES]),
      .new_rec (new_rec),
      .q       (q[i])
    );
  end

  sve_unit u_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (unit_start),
    .head       (q[0]),
    .amplitude  (amp_r),
    .drop_thr   (drop_r),
    .res        (res),
    .upd        (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        case (in_ch.action)
          ACT_TICK: begin
            len_r <= cnt_r;
            rem_r <= cnt_r;
            sum_r <= '0;
          end
          ACT_ADD: begin
            if (cnt_r != CNT_W'(VOICES)) cnt_r <= cnt_r + CNT_W'(1);
          end
          ACT_REMOVE: begin
            if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
          end
          default: ;
        endcase
      end else if (state_r == ST_WAIT && res.done) begin
        sum_r <= sum_r + SUM_W'(res.term);
        rem_r <= rem_r - CNT_W'(1);
        if (!res.keep) len_r <= len_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) cnt_r <= res.keep ? len_r : len_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r   <= AMPLITUDE_RST;
      dsel_r  <= DECAY_SELECT_RST;
      arate_r <= ATTACK_RATE_RST;
      drop_r  <= DROP_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AMPLITUDE:    amp_r   <= cfg_data[15:0];
        CFG_DECAY_SELECT: dsel_r  <= cfg_data[3:0];
        CFG_ATTACK_RATE:  arate_r <= cfg_data;
        CFG_DROP_LEVEL:   drop_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sum_r > SUM_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (sum_r < -SUM_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = sum_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= sat;
      out_active_r <= 4'(cnt_r);
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample        = out_sample_r;
  assign out_ch.voices_active = out_active_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VOICES)) else $error("voice count above capacity");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> state_r == ST_WAIT) else $error("voice unit finished outside a tick");

  a_rem_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START || state_r == ST_WAIT) |-> (rem_r <= len_r && rem_r != '0))
    else $error("tick window smaller than voices left");

endmodule

@@ rtl/core/sve_cell.sv @@
// ----------------------------------------------------------------------------
// sve_cell
// One voice slot of the chain; takes its right neighbor or a new record.
// ----------------------------------------------------------------------------
module sve_cell (
  input  logic               clk,
  input  sve_pkg::cell_ctl_t ctl,
  input  sve_pkg::voice_t    right,
  input  sve_pkg::voice_t    new_rec,
  output sve_pkg::voice_t    q
);
  import sve_pkg::*;

  voice_t rec_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rec_r <= new_rec;
    end else if (ctl.shift) begin
      rec_r <= right;
    end
  end

  assign q = rec_r;

endmodule

@@ rtl/core/sve_unit.sv @@
// ----------------------------------------------------------------------------
// sve_unit
// Voice processor: one shared multiplier stepped through sine, envelope
// and level updates of the voice at the head of the chain.
// ----------------------------------------------------------------------------
module sve_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sve_pkg::voice_t     head,
  input  logic [15:0]         amplitude,
  input  logic [23:0]         drop_thr,
  output sve_pkg::unit_res_t  res,
  output sve_pkg::voice_t     upd
);
  import sve_pkg::*;

  localparam int QB = SINE_TABLE_BITS - 2;

  logic                      busy_r;
  mstep_t                    step_r;
  logic [PROD_W-1:0]         prod_r;
  logic [16:0]               x2_r;
  logic [14:0]               s_r;
  logic [16:0]               term_r;
  logic [LEVEL_W-1:0]        att_new_r;

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [QB-1:0]              qpos;
  logic [QB:0]                pos;
  logic [16:0]                x;
  logic [MUL_W-1:0]           g;
  logic [15:0]                t1;
  logic [16:0]                t2;
  logic [15:0]                s_raw;
  logic [14:0]                s_cap;
  logic [MUL_W-1:0]           op_a, op_b;
  logic [PROD_W-1:0]          prod_nxt;
  logic [LEVEL_W-1:0]         dec_new;
  logic                       frozen;
  logic                       done;

  assign idx    = head.phase[PHASE_W-1 -: SINE_TABLE_BITS];
  assign qpos   = idx[QB-1:0];
  // odd quadrants run the quarter wave backward
  assign pos    = idx[QB] ? ((QB+1)'(1) << QB) - (QB+1)'(qpos) : (QB+1)'(qpos);
  assign x      = 17'(pos) << (18 - SINE_TABLE_BITS);
  assign g      = (MUL_W'(1) << LEVEL_W) - MUL_W'(head.att);

  assign t1     = SINE_C3 - prod_r[31:16];
  assign t2     = SINE_C1 - prod_r[32:16];
  assign s_raw  = prod_r[32:17];
  assign s_cap  = (s_raw > 16'd32767) ? 15'h7FFF : s_raw[14:0];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_r)
      MS_XX:   begin op_a = MUL_W'(x);              op_b = MUL_W'(x);          end
      MS_X2C5: begin op_a = MUL_W'(prod_r[32:16]);  op_b = MUL_W'(SINE_C5);    end
      MS_T1:   begin op_a = MUL_W'(x2_r);           op_b = MUL_W'(t1);         end
      MS_T2:   begin op_a = MUL_W'(x);              op_b = MUL_W'(t2);         end
      MS_GD:   begin op_a = g;                      op_b = MUL_W'(head.dec);   end
      MS_EA:   begin op_a = prod_r[48:24];          op_b = MUL_W'(amplitude);  end
      MS_ES:   begin op_a = prod_r[40:16];          op_b = MUL_W'(s_r);        end
      MS_ATT:  begin op_a = MUL_W'(head.att);       op_b = MUL_W'(head.arate); end
      MS_DEC:  begin op_a = MUL_W'(head.dec);       op_b = MUL_W'(head.drate); end
      default: begin op_a = '0;                     op_b = '0;                 end
    endcase
  end

  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);
  assign dec_new  = prod_r[47:24];
  assign frozen   = (head.step == '0);
  assign done     = busy_r && (frozen || step_r == MS_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= MS_XX;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= MS_XX;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      step_r <= mstep_t'(step_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (step_r)
      MS_X2C5: x2_r      <= prod_r[32:16];
      MS_GD:   s_r       <= s_cap;
      MS_ATT:  term_r    <= prod_r[40:24];
      MS_DEC:  att_new_r <= prod_r[47:24];
      default: ;
    endcase
  end

  always_comb begin
    res.done = done;
    res.keep = frozen || (dec_new >= drop_thr);
    if (frozen) begin
      res.term = '0;
    end else if (head.phase[PHASE_W-1]) begin
      res.term = -TERM_W'(term_r);
    end else begin
      res.term = TERM_W'(term_r);
    end
    if (frozen) begin
      upd = head;
    end else begin
      upd.phase = head.phase + head.step;
      upd.step  = head.step;
      upd.att   = att_new_r;
      upd.dec   = dec_new;
      upd.arate = head.arate;
      upd.drate = head.drate;
    end
  end

endmodule
